// ===== rtl/velocity_command_gate_watchdog_macros.svh =====
// assertion macros for the asserting files (only velocity_command_gate_watchdog.sv includes them)
`ifndef VELOCITY_COMMAND_GATE_WATCHDOG_MACROS_SVH
`define VELOCITY_COMMAND_GATE_WATCHDOG_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define VCGW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vcgw assertion failed");

// next-cycle implication, disabled while reset is low
`define VCGW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vcgw assertion failed");

`endif

// ===== rtl/vcgw_pkg.sv =====
`default_nettype none
package vcgw_pkg;

    // datapath widths
    localparam int VEL_WIDTH  = 16;
    localparam int AGE_WIDTH  = 16;
    localparam int LIM_WIDTH  = 15;
    localparam int PER_WIDTH  = 10;
    localparam int DUR_WIDTH  = 11;
    localparam int TMO_WIDTH  = 16;
    localparam int SEQ_WIDTH  = 32;
    localparam int RSN_WIDTH  = 3;
    localparam int ACT_WIDTH  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CMP_WIDTH  = (AGE_WIDTH > TMO_WIDTH) ? AGE_WIDTH : TMO_WIDTH;
    localparam int EXT_WIDTH  = ((VEL_WIDTH > LIM_WIDTH + 1) ? VEL_WIDTH : LIM_WIDTH + 1) + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ARMED         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_VX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_VY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_WZ      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RESEND_TICKS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DURATION = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 3'd7;

    // configuration reset values
    localparam logic [LIM_WIDTH-1:0] RST_LIMIT_VX      = 15'd410;
    localparam logic [LIM_WIDTH-1:0] RST_LIMIT_VY      = 15'd205;
    localparam logic [LIM_WIDTH-1:0] RST_LIMIT_WZ      = 15'd614;
    localparam logic [LIM_WIDTH-1:0] RST_DEADBAND      = 15'd4;
    localparam logic [PER_WIDTH-1:0] RST_RESEND_TICKS  = 10'd100;
    localparam logic [DUR_WIDTH-1:0] RST_HOLD_DURATION = 11'd200;
    localparam logic [TMO_WIDTH-1:0] RST_TIMEOUT_LIMIT = 16'd400;

    // input action codes
    localparam logic [ACT_WIDTH-1:0] ACT_COMMAND = 2'd0;
    localparam logic [ACT_WIDTH-1:0] ACT_TICK    = 2'd1;
    localparam logic [ACT_WIDTH-1:0] ACT_STOP    = 2'd2;
    localparam logic [ACT_WIDTH-1:0] ACT_UNUSED  = 2'd3;

    // result reason codes
    localparam logic [RSN_WIDTH-1:0] RSN_FORWARD  = 3'd0;
    localparam logic [RSN_WIDTH-1:0] RSN_RESEND   = 3'd1;
    localparam logic [RSN_WIDTH-1:0] RSN_INVALID  = 3'd2;
    localparam logic [RSN_WIDTH-1:0] RSN_ZERO     = 3'd3;
    localparam logic [RSN_WIDTH-1:0] RSN_DISARMED = 3'd4;
    localparam logic [RSN_WIDTH-1:0] RSN_TIMEOUT  = 3'd5;
    localparam logic [RSN_WIDTH-1:0] RSN_STOP_REQ = 3'd6;

    typedef struct packed {
        logic                 armed;
        logic [LIM_WIDTH-1:0] limit_vx;
        logic [LIM_WIDTH-1:0] limit_vy;
        logic [LIM_WIDTH-1:0] limit_wz;
        logic [LIM_WIDTH-1:0] deadband;
        logic [PER_WIDTH-1:0] resend_ticks;
        logic [DUR_WIDTH-1:0] hold_duration;
        logic [TMO_WIDTH-1:0] timeout_limit;
    } t_cfg;

    typedef struct packed {
        logic [ACT_WIDTH-1:0]        action;
        logic signed [VEL_WIDTH-1:0] vx;
        logic signed [VEL_WIDTH-1:0] vy;
        logic signed [VEL_WIDTH-1:0] wz;
        logic                        invalid;
    } t_item;

    typedef struct packed {
        logic signed [VEL_WIDTH-1:0] vx;
        logic signed [VEL_WIDTH-1:0] vy;
        logic signed [VEL_WIDTH-1:0] wz;
        logic [DUR_WIDTH-1:0]        duration_ms;
        logic [SEQ_WIDTH-1:0]        request_id;
        logic [RSN_WIDTH-1:0]        reason_code;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/vcgw_in_if.sv =====
`default_nettype none
interface vcgw_in_if;
    import vcgw_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [ACT_WIDTH-1:0]        action;
    logic signed [VEL_WIDTH-1:0] cmd_vx;
    logic signed [VEL_WIDTH-1:0] cmd_vy;
    logic signed [VEL_WIDTH-1:0] cmd_wz;
    logic                        invalid;

    modport source (output valid, action, cmd_vx, cmd_vy, cmd_wz, invalid, input ready);
    modport sink   (input valid, action, cmd_vx, cmd_vy, cmd_wz, invalid, output ready);
endinterface
`default_nettype wire

// ===== rtl/vcgw_out_if.sv =====
`default_nettype none
interface vcgw_out_if;
    import vcgw_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [VEL_WIDTH-1:0] out_vx;
    logic signed [VEL_WIDTH-1:0] out_vy;
    logic signed [VEL_WIDTH-1:0] out_wz;
    logic [DUR_WIDTH-1:0]        duration_ms;
    logic [SEQ_WIDTH-1:0]        request_id;
    logic [RSN_WIDTH-1:0]        reason_code;

    modport source (output valid, out_vx, out_vy, out_wz, duration_ms, request_id,
                    reason_code, input ready);
    modport sink   (input valid, out_vx, out_vy, out_wz, duration_ms, request_id,
                    reason_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/velocity_command_gate_watchdog.sv =====
// channel   dir  modport  payload
// i_cmd     in   sink     action, cmd_vx, cmd_vy, cmd_wz, invalid
// o_res     out  source   out_vx, out_vy, out_wz, duration_ms, request_id, reason_code
// i_cfg_*   in   -        write enable, register index, write data
//
// one item per cycle unless o_res stalls; a result goes via the input and result registers
// the stage between the input register and the result register does shaping and state update
// i_cmd.ready follows o_res.ready in the same cycle while both registers are full
// synchronous active-low reset clears config to defaults and all control state
// items that give no result still pass through the input register and update state
`default_nettype none
`include "velocity_command_gate_watchdog_macros.svh"
module velocity_command_gate_watchdog (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [vcgw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [vcgw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    vcgw_in_if.sink                              i_cmd,
    vcgw_out_if.source                           o_res
);
    import vcgw_pkg::*;

    t_cfg    w_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_item   w_item;
    logic    w_emit;
    t_result w_res;
    t_result r_out;
    logic    r_out_valid;
    logic    w_advance;
    logic    w_load;
    logic    w_take;

    vcgw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // handshake control
    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_take      = i_cmd.valid && i_cmd.ready;
    assign w_load      = w_advance && w_emit;
    assign i_cmd.ready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.action  <= i_cmd.action;
            r_in.vx      <= i_cmd.cmd_vx;
            r_in.vy      <= i_cmd.cmd_vy;
            r_in.wz      <= i_cmd.cmd_wz;
            r_in.invalid <= i_cmd.invalid;
        end
    end

    // per-axis clamp and deadband
    vcgw_shape u_shape_vx (
        .i_v        (r_in.vx),
        .i_limit    (w_cfg.limit_vx),
        .i_deadband (w_cfg.deadband),
        .o_v        (w_item.vx)
    );

    vcgw_shape u_shape_vy (
        .i_v        (r_in.vy),
        .i_limit    (w_cfg.limit_vy),
        .i_deadband (w_cfg.deadband),
        .o_v        (w_item.vy)
    );

    vcgw_shape u_shape_wz (
        .i_v        (r_in.wz),
        .i_limit    (w_cfg.limit_wz),
        .i_deadband (w_cfg.deadband),
        .o_v        (w_item.wz)
    );

    assign w_item.action  = r_in.action;
    assign w_item.invalid = r_in.invalid;

    vcgw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_advance),
        .i_item  (w_item),
        .i_cfg   (w_cfg),
        .o_emit  (w_emit),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_vx      = r_out.vx;
    assign o_res.out_vy      = r_out.vy;
    assign o_res.out_wz      = r_out.wz;
    assign o_res.duration_ms = r_out.duration_ms;
    assign o_res.request_id  = r_out.request_id;
    assign o_res.reason_code = r_out.reason_code;

    // checks
    `VCGW_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n,
        o_res.valid && o_res.ready && !w_load, !o_res.valid)
    `VCGW_ASSERT_NEXT(a_in_kept, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid)
    `VCGW_ASSERT_NOW(a_stop_is_zero, i_clk, i_rst_n,
        o_res.valid && o_res.reason_code != RSN_FORWARD && o_res.reason_code != RSN_RESEND,
        o_res.out_vx == '0 && o_res.out_vy == '0 && o_res.out_wz == '0)
endmodule
`default_nettype wire

// ===== rtl/vcgw_cfg.sv =====
`default_nettype none
module vcgw_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [vcgw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [vcgw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output vcgw_pkg::t_cfg                      o_cfg
);
    import vcgw_pkg::*;

    t_cfg r_cfg;

    // register file, written one register per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.armed         <= 1'b0;
            r_cfg.limit_vx      <= RST_LIMIT_VX;
            r_cfg.limit_vy      <= RST_LIMIT_VY;
            r_cfg.limit_wz      <= RST_LIMIT_WZ;
            r_cfg.deadband      <= RST_DEADBAND;
            r_cfg.resend_ticks  <= RST_RESEND_TICKS;
            r_cfg.hold_duration <= RST_HOLD_DURATION;
            r_cfg.timeout_limit <= RST_TIMEOUT_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ARMED:         r_cfg.armed         <= i_cfg_data[0];
                REG_LIMIT_VX:      r_cfg.limit_vx      <= i_cfg_data[LIM_WIDTH-1:0];
                REG_LIMIT_VY:      r_cfg.limit_vy      <= i_cfg_data[LIM_WIDTH-1:0];
                REG_LIMIT_WZ:      r_cfg.limit_wz      <= i_cfg_data[LIM_WIDTH-1:0];
                REG_DEADBAND:      r_cfg.deadband      <= i_cfg_data[LIM_WIDTH-1:0];
                REG_RESEND_TICKS:  r_cfg.resend_ticks  <= i_cfg_data[PER_WIDTH-1:0];
                REG_HOLD_DURATION: r_cfg.hold_duration <= i_cfg_data[DUR_WIDTH-1:0];
                REG_TIMEOUT_LIMIT: r_cfg.timeout_limit <= i_cfg_data[TMO_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// ===== rtl/vcgw_shape.sv =====
`default_nettype none
module vcgw_shape (
    input  wire logic signed [vcgw_pkg::VEL_WIDTH-1:0] i_v,
    input  wire logic [vcgw_pkg::LIM_WIDTH-1:0]        i_limit,
    input  wire logic [vcgw_pkg::LIM_WIDTH-1:0]        i_deadband,
    output logic signed [vcgw_pkg::VEL_WIDTH-1:0]      o_v
);
    import vcgw_pkg::*;

    logic signed [EXT_WIDTH-1:0] w_v;
    logic signed [EXT_WIDTH-1:0] w_lim;
    logic signed [EXT_WIDTH-1:0] w_db;
    logic signed [EXT_WIDTH-1:0] w_clamp;
    logic signed [EXT_WIDTH-1:0] w_mag;

    // clamp to +/- limit, then zero inside the deadband
    always_comb begin
        w_v   = EXT_WIDTH'(i_v);
        w_lim = signed'(EXT_WIDTH'(i_limit));
        w_db  = signed'(EXT_WIDTH'(i_deadband));
        priority if (w_v > w_lim) begin
            w_clamp = w_lim;
        end else if (w_v < -w_lim) begin
            w_clamp = -w_lim;
        end else begin
            w_clamp = w_v;
        end
        w_mag = (w_clamp < 0) ? -w_clamp : w_clamp;
        o_v   = (w_mag < w_db) ? '0 : VEL_WIDTH'(w_clamp);
    end
endmodule
`default_nettype wire

// ===== rtl/vcgw_ctrl.sv =====
`default_nettype none
module vcgw_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire vcgw_pkg::t_item i_item,
    input  wire vcgw_pkg::t_cfg  i_cfg,
    output logic                o_emit,
    output vcgw_pkg::t_result   o_res
);
    import vcgw_pkg::*;

    localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

    logic signed [VEL_WIDTH-1:0] r_held_vx, n_held_vx;
    logic signed [VEL_WIDTH-1:0] r_held_vy, n_held_vy;
    logic signed [VEL_WIDTH-1:0] r_held_wz, n_held_wz;
    logic                        r_holding, n_holding;
    logic [AGE_WIDTH-1:0]        r_age, n_age;
    logic [PER_WIDTH-1:0]        r_period, n_period;
    logic [SEQ_WIDTH-1:0]        r_seq, n_seq;

    logic [AGE_WIDTH-1:0] w_age_inc;
    logic [PER_WIDTH-1:0] w_period_inc;
    logic                 w_zero;
    logic                 w_stop;

    // decision for one item and next state
    always_comb begin
        n_held_vx = r_held_vx;
        n_held_vy = r_held_vy;
        n_held_wz = r_held_wz;
        n_holding = r_holding;
        n_age     = r_age;
        n_period  = r_period;
        o_emit    = 1'b0;
        w_stop    = 1'b0;
        o_res.vx          = '0;
        o_res.vy          = '0;
        o_res.wz          = '0;
        o_res.duration_ms = i_cfg.hold_duration;
        o_res.request_id  = r_seq;
        o_res.reason_code = RSN_STOP_REQ;

        w_age_inc    = (r_age == AGE_MAX) ? r_age : r_age + 1'b1;
        w_period_inc = r_period + 1'b1;
        w_zero       = (i_item.vx == '0) && (i_item.vy == '0) && (i_item.wz == '0);

        unique case (i_item.action)
            ACT_COMMAND: begin
                priority if (i_item.invalid) begin
                    w_stop            = 1'b1;
                    o_res.reason_code = RSN_INVALID;
                end else if (w_zero) begin
                    w_stop            = 1'b1;
                    n_age             = '0;
                    o_res.reason_code = RSN_ZERO;
                end else if (!i_cfg.armed) begin
                    if (r_holding) begin
                        w_stop            = 1'b1;
                        o_res.reason_code = RSN_DISARMED;
                    end
                end else begin
                    o_emit            = 1'b1;
                    n_held_vx         = i_item.vx;
                    n_held_vy         = i_item.vy;
                    n_held_wz         = i_item.wz;
                    n_holding         = 1'b1;
                    n_age             = '0;
                    o_res.vx          = i_item.vx;
                    o_res.vy          = i_item.vy;
                    o_res.wz          = i_item.wz;
                    o_res.reason_code = RSN_FORWARD;
                end
            end
            ACT_TICK: begin
                n_age = w_age_inc;
                if (w_period_inc < i_cfg.resend_ticks) begin
                    n_period = w_period_inc;
                end else begin
                    n_period = '0;
                    if (i_cfg.armed && r_holding) begin
                        if (CMP_WIDTH'(w_age_inc) > CMP_WIDTH'(i_cfg.timeout_limit)) begin
                            w_stop            = 1'b1;
                            o_res.reason_code = RSN_TIMEOUT;
                        end else begin
                            o_emit            = 1'b1;
                            o_res.vx          = r_held_vx;
                            o_res.vy          = r_held_vy;
                            o_res.wz          = r_held_wz;
                            o_res.reason_code = RSN_RESEND;
                        end
                    end
                end
            end
            ACT_STOP: begin
                w_stop            = 1'b1;
                o_res.reason_code = RSN_STOP_REQ;
            end
            ACT_UNUSED: ;
            default: ;
        endcase

        // any stop clears the held target
        if (w_stop) begin
            o_emit    = 1'b1;
            n_held_vx = '0;
            n_held_vy = '0;
            n_held_wz = '0;
            n_holding = 1'b0;
        end
        n_seq = o_emit ? r_seq + 1'b1 : r_seq;
    end

    // state update on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_vx <= '0;
            r_held_vy <= '0;
            r_held_wz <= '0;
            r_holding <= 1'b0;
            r_age     <= '0;
            r_period  <= '0;
            r_seq     <= '0;
        end else if (i_fire) begin
            r_held_vx <= n_held_vx;
            r_held_vy <= n_held_vy;
            r_held_wz <= n_held_wz;
            r_holding <= n_holding;
            r_age     <= n_age;
            r_period  <= n_period;
            r_seq     <= n_seq;
        end
    end
endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import vcgw_pkg::*;

    localparam int  PHASE_COUNT   = 9;
    localparam int  PHASE_ITEMS   = 65;
    localparam int  AGING_TICKS   = 40;
    localparam int  SETTLE_CYCLES = 4;
    localparam int  DRAIN_LIMIT   = 1000;
    localparam time RUN_LIMIT_NS  = 40_000_000;

    // directed rows: register write, predicted item, item with no result, typed result
    typedef enum int {ROW_CFG, ROW_PRED, ROW_QUIET, ROW_TYPED} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        t_item                  item;
        t_result                want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vcgw_in_if  cmd_if ();
    vcgw_out_if res_if ();

    velocity_command_gate_watchdog u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd_if),
        .o_res       (res_if)
    );

    // predictor state, mirrors the gate after reset
    t_cfg                  gate_cfg;
    logic signed [VEL_WIDTH-1:0] held_vx, held_vy, held_wz;
    bit                    holding;
    logic [AGE_WIDTH-1:0]  command_age;
    logic [PER_WIDTH-1:0]  period_count;
    logic [SEQ_WIDTH-1:0]  next_request_id;

    t_result  pending_results[$];
    t_dir_row dir_rows[$];
    bit       failed;
    bit       snd_quiet, snd_sparse, rcv_quiet;

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // clamp to the limit, then zero inside the deadband
    function automatic logic signed [VEL_WIDTH-1:0] shape_axis(
        input logic signed [VEL_WIDTH-1:0] v, input logic [LIM_WIDTH-1:0] lim);
        int x, l, mag;
        x = v;
        l = lim;
        if (x > l) x = l;
        if (x < -l) x = -l;
        mag = (x < 0) ? -x : x;
        if (x == 0 || mag < int'(gate_cfg.deadband)) return '0;
        return x[VEL_WIDTH-1:0];
    endfunction

    function automatic void gate_config(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ARMED:         gate_cfg.armed         = data[0];
            REG_LIMIT_VX:      gate_cfg.limit_vx      = data[LIM_WIDTH-1:0];
            REG_LIMIT_VY:      gate_cfg.limit_vy      = data[LIM_WIDTH-1:0];
            REG_LIMIT_WZ:      gate_cfg.limit_wz      = data[LIM_WIDTH-1:0];
            REG_DEADBAND:      gate_cfg.deadband      = data[LIM_WIDTH-1:0];
            REG_RESEND_TICKS:  gate_cfg.resend_ticks  = data[PER_WIDTH-1:0];
            REG_HOLD_DURATION: gate_cfg.hold_duration = data[DUR_WIDTH-1:0];
            REG_TIMEOUT_LIMIT: gate_cfg.timeout_limit = data[TMO_WIDTH-1:0];
            default: ;
        endcase
    endfunction

    // one item through the gate; returns 1 when it emits a result
    function automatic bit gate_step(input t_item it, output t_result res);
        logic signed [VEL_WIDTH-1:0] sx, sy, sz;
        bit                   fire;
        bit                   is_stop;
        logic [RSN_WIDTH-1:0] why;
        fire    = 1'b0;
        is_stop = 1'b1;
        why     = RSN_STOP_REQ;
        res     = '0;
        case (it.action)
            ACT_COMMAND: begin
                sx = shape_axis(it.vx, gate_cfg.limit_vx);
                sy = shape_axis(it.vy, gate_cfg.limit_vy);
                sz = shape_axis(it.wz, gate_cfg.limit_wz);
                if (it.invalid) begin
                    fire = 1'b1;
                    why  = RSN_INVALID;
                end else if (sx == 0 && sy == 0 && sz == 0) begin
                    command_age = '0;
                    fire        = 1'b1;
                    why         = RSN_ZERO;
                end else if (!gate_cfg.armed) begin
                    if (holding) begin
                        fire = 1'b1;
                        why  = RSN_DISARMED;
                    end
                end else begin
                    held_vx     = sx;
                    held_vy     = sy;
                    held_wz     = sz;
                    holding     = 1'b1;
                    command_age = '0;
                    fire        = 1'b1;
                    is_stop     = 1'b0;
                    why         = RSN_FORWARD;
                end
            end
            ACT_TICK: begin
                if (command_age != '1) command_age++;
                period_count++;
                if (period_count >= gate_cfg.resend_ticks) begin
                    period_count = '0;
                    if (gate_cfg.armed && holding) begin
                        fire = 1'b1;
                        if (command_age > gate_cfg.timeout_limit) begin
                            why = RSN_TIMEOUT;
                        end else begin
                            is_stop = 1'b0;
                            why     = RSN_RESEND;
                        end
                    end
                end
            end
            ACT_STOP: fire = 1'b1;
            default: ;
        endcase
        if (fire && is_stop) begin
            held_vx = '0;
            held_vy = '0;
            held_wz = '0;
            holding = 1'b0;
        end
        if (fire) begin
            res.vx          = held_vx;
            res.vy          = held_vy;
            res.wz          = held_wz;
            res.duration_ms = gate_cfg.hold_duration;
            res.request_id  = next_request_id;
            res.reason_code = why;
            next_request_id++;
        end
        return fire;
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        t_dir_row r;
        r.kind     = ROW_CFG;
        r.reg_idx  = idx;
        r.reg_data = data;
        r.item     = '0;
        r.want     = '0;
        return r;
    endfunction

    function automatic t_dir_row cmd_row(input t_row_kind kind, input logic [ACT_WIDTH-1:0] act,
                                         input int vx, input int vy, input int wz, input bit inv);
        t_dir_row r;
        r.kind         = kind;
        r.reg_idx      = '0;
        r.reg_data     = '0;
        r.item         = '0;
        r.want         = '0;
        r.item.action  = act;
        r.item.vx      = vx[VEL_WIDTH-1:0];
        r.item.vy      = vy[VEL_WIDTH-1:0];
        r.item.wz      = wz[VEL_WIDTH-1:0];
        r.item.invalid = inv;
        return r;
    endfunction

    function automatic t_dir_row typed_row(input logic [ACT_WIDTH-1:0] act,
                                           input int vx, input int vy, input int wz,
                                           input bit inv, input int evx, input int evy,
                                           input int ewz, input logic [RSN_WIDTH-1:0] rsn);
        t_dir_row r;
        r                  = cmd_row(ROW_TYPED, act, vx, vy, wz, inv);
        r.want.vx          = evx[VEL_WIDTH-1:0];
        r.want.vy          = evy[VEL_WIDTH-1:0];
        r.want.wz          = ewz[VEL_WIDTH-1:0];
        r.want.reason_code = rsn;
        return r;
    endfunction

    // velocity mix: full range, zero, extremes, around the deadband, around the limit
    function automatic logic [VEL_WIDTH-1:0] rand_axis(input int lim, input int db);
        int v;
        case ($urandom_range(0, 9))
            0:       v = int'($urandom);
            1:       v = 0;
            2:       v = $urandom_range(0, 1) ? 32767 : -32768;
            3, 4:    v = db - 1 + int'($urandom_range(0, 2));
            default: v = int'($urandom_range(0, lim + lim / 4 + 1));
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v[VEL_WIDTH-1:0];
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    r;
        r          = $urandom_range(0, 99);
        it.vx      = rand_axis(int'(gate_cfg.limit_vx), int'(gate_cfg.deadband));
        it.vy      = rand_axis(int'(gate_cfg.limit_vy), int'(gate_cfg.deadband));
        it.wz      = rand_axis(int'(gate_cfg.limit_wz), int'(gate_cfg.deadband));
        it.invalid = ($urandom_range(0, 19) == 0);
        if (r < 48) begin
            it.action = ACT_COMMAND;
            if ($urandom_range(0, 9) == 0) begin
                it.vx = '0;
                it.vy = '0;
                it.wz = '0;
            end
        end else if (r < 88) begin
            it.action = ACT_TICK;
        end else if (r < 95) begin
            it.action = ACT_STOP;
        end else begin
            it.action = ACT_UNUSED;
        end
        return it;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg(input int lo, input int hi,
                                                       input int typ_lo, input int typ_hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return lo[CFG_DATA_W-1:0];
        if (r == 1) return hi[CFG_DATA_W-1:0];
        if (r < 4) return CFG_DATA_W'($urandom_range(lo, hi));
        return CFG_DATA_W'($urandom_range(typ_lo, typ_hi));
    endfunction

    function automatic int sender_gap();
        if (snd_quiet) return 0;
        if (snd_sparse) return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 7) : 0;
        return $urandom_range(0, 7);
    endfunction

    // offer one item, wait for the transfer, then predict its result
    task automatic send_item(input t_item it, input t_row_kind kind, input t_result want);
        int      gap;
        bit      has;
        t_result res;
        gap = sender_gap();
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.action  <= it.action;
        cmd_if.cmd_vx  <= it.vx;
        cmd_if.cmd_vy  <= it.vy;
        cmd_if.cmd_wz  <= it.wz;
        cmd_if.invalid <= it.invalid;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        has = gate_step(it, res);
        if (kind == ROW_QUIET) begin
            has = 1'b0;
        end else if (kind == ROW_TYPED) begin
            has             = 1'b1;
            res.vx          = want.vx;
            res.vy          = want.vy;
            res.wz          = want.wz;
            res.reason_code = want.reason_code;
        end
        if (has) pending_results.push_back(res);
    endtask

    // stop sending and let every expected result come out, then let the pipe empty
    task automatic drain_results();
        int waited;
        waited = 0;
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            failed = 1'b1;
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        gate_config(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    // register settings per random phase, extremes in the fixed ones
    task automatic program_phase(input int ph);
        logic [CFG_DATA_W-1:0] vals [8];
        if (ph == 0) begin
            vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        end else if (ph == 1) begin
            vals = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd20, 16'd1, 16'd1};
        end else if (ph == PHASE_COUNT - 1) begin
            vals = '{16'd1, 16'd32767, 16'd32767, 16'd32767, 16'd32767, 16'd0, 16'd2000,
                     16'd65535};
        end else begin
            vals[REG_ARMED]         = (ph == 2) ? 16'd0 : 16'($urandom_range(0, 4) != 0);
            vals[REG_LIMIT_VX]      = pick_reg(0, 32767, 1, 2000);
            vals[REG_LIMIT_VY]      = pick_reg(0, 32767, 1, 2000);
            vals[REG_LIMIT_WZ]      = pick_reg(0, 32767, 1, 2000);
            vals[REG_DEADBAND]      = pick_reg(0, 32767, 0, 40);
            vals[REG_RESEND_TICKS]  = pick_reg(0, 1023, 0, 25);
            vals[REG_HOLD_DURATION] = pick_reg(0, 2047, 1, 2000);
            vals[REG_TIMEOUT_LIMIT] = pick_reg(0, 65535, 1, 60);
        end
        for (int k = 0; k < 8; k++) cfg_write(k[CFG_IDX_W-1:0], vals[k]);
    endtask

    task automatic field_mismatch(input string field, input longint want_v, input longint got_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
        failed = 1'b1;
    endtask

    // result side: random stalls, each transfer checked against the oldest expectation
    initial begin
        int      stall;
        t_result got, want;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rcv_quiet ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            got.vx          = res_if.out_vx;
            got.vy          = res_if.out_vy;
            got.wz          = res_if.out_wz;
            got.duration_ms = res_if.duration_ms;
            got.request_id  = res_if.request_id;
            got.reason_code = res_if.reason_code;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, reason %0d request_id %0d", $time,
                         got.reason_code, got.request_id);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (got.vx !== want.vx) field_mismatch("out_vx", want.vx, got.vx);
                if (got.vy !== want.vy) field_mismatch("out_vy", want.vy, got.vy);
                if (got.wz !== want.wz) field_mismatch("out_wz", want.wz, got.wz);
                if (got.duration_ms !== want.duration_ms)
                    field_mismatch("duration_ms", want.duration_ms, got.duration_ms);
                if (got.request_id !== want.request_id)
                    field_mismatch("request_id", want.request_id, got.request_id);
                if (got.reason_code !== want.reason_code)
                    field_mismatch("reason_code", want.reason_code, got.reason_code);
            end
        end
    end

    // stimulus
    initial begin
        t_item it;
        failed          = 1'b0;
        snd_quiet       = 1'b0;
        snd_sparse      = 1'b0;
        rcv_quiet       = 1'b0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        cmd_if.valid   <= 1'b0;
        cmd_if.action  <= ACT_COMMAND;
        cmd_if.cmd_vx  <= '0;
        cmd_if.cmd_vy  <= '0;
        cmd_if.cmd_wz  <= '0;
        cmd_if.invalid <= 1'b0;

        // predictor reset state
        gate_cfg.armed         = 1'b0;
        gate_cfg.limit_vx      = RST_LIMIT_VX;
        gate_cfg.limit_vy      = RST_LIMIT_VY;
        gate_cfg.limit_wz      = RST_LIMIT_WZ;
        gate_cfg.deadband      = RST_DEADBAND;
        gate_cfg.resend_ticks  = RST_RESEND_TICKS;
        gate_cfg.hold_duration = RST_HOLD_DURATION;
        gate_cfg.timeout_limit = RST_TIMEOUT_LIMIT;
        held_vx         = '0;
        held_vy         = '0;
        held_wz         = '0;
        holding         = 1'b0;
        command_age     = '0;
        period_count    = '0;
        next_request_id = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, starting from reset settings (disarmed)
        dir_rows = '{
            typed_row(ACT_COMMAND, 0, 0, 0, 0, 0, 0, 0, RSN_ZERO),
            cmd_row(ROW_QUIET, ACT_COMMAND, 32767, -32768, 100, 0),
            typed_row(ACT_COMMAND, 32767, 32767, 32767, 1, 0, 0, 0, RSN_INVALID),
            typed_row(ACT_STOP, -32768, -32768, -32768, 0, 0, 0, 0, RSN_STOP_REQ),
            cmd_row(ROW_QUIET, ACT_UNUSED, -1, -1, -1, 1),
            cmd_row(ROW_QUIET, ACT_TICK, 0, 0, 0, 0),
            cfg_row(REG_ARMED, 16'd1),
            typed_row(ACT_COMMAND, 32767, -32768, 32767, 0, 410, -205, 614, RSN_FORWARD),
            typed_row(ACT_COMMAND, -32768, 32767, -32768, 0, -410, 205, -614, RSN_FORWARD),
            typed_row(ACT_COMMAND, 3, -3, 3, 0, 0, 0, 0, RSN_ZERO),
            typed_row(ACT_COMMAND, 4, -4, 0, 0, 4, -4, 0, RSN_FORWARD),
            cmd_row(ROW_PRED, ACT_COMMAND, 1234, -77, 300, 0),
            cfg_row(REG_ARMED, 16'd0),
            typed_row(ACT_COMMAND, 200, 0, 0, 0, 0, 0, 0, RSN_DISARMED),
            cmd_row(ROW_QUIET, ACT_COMMAND, 200, 0, 0, 0),
            cfg_row(REG_ARMED, 16'd1),
            cmd_row(ROW_PRED, ACT_COMMAND, 1000, 50, -50, 0),
            cfg_row(REG_RESEND_TICKS, 16'd0),
            cmd_row(ROW_PRED, ACT_TICK, 0, 0, 0, 0),
            cfg_row(REG_TIMEOUT_LIMIT, 16'd1),
            typed_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, RSN_TIMEOUT),
            cmd_row(ROW_QUIET, ACT_TICK, 0, 0, 0, 0),
            cfg_row(REG_LIMIT_VX, 16'd0),
            typed_row(ACT_COMMAND, 5000, 0, 0, 0, 0, 0, 0, RSN_ZERO),
            cmd_row(ROW_PRED, ACT_COMMAND, 5000, 300, -32768, 0),
            cfg_row(REG_RESEND_TICKS, 16'd1),
            cmd_row(ROW_PRED, ACT_TICK, 0, 0, 0, 0),
            cmd_row(ROW_PRED, ACT_STOP, 0, 0, 0, 0)
        };
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG)
                cfg_write(dir_rows[k].reg_idx, dir_rows[k].reg_data);
            else
                send_item(dir_rows[k].item, dir_rows[k].kind, dir_rows[k].want);
        end

        // ageing: with the largest timeout a held target keeps being resent
        cfg_write(REG_LIMIT_VX, 16'(RST_LIMIT_VX));
        cfg_write(REG_RESEND_TICKS, 16'd10);
        cfg_write(REG_TIMEOUT_LIMIT, 16'd65535);
        it = rand_item();
        it.action  = ACT_COMMAND;
        it.vx      = 16'sd300;
        it.invalid = 1'b0;
        send_item(it, ROW_PRED, '0);
        snd_sparse = 1'b1;
        for (int n = 0; n < AGING_TICKS; n++) begin
            it = rand_item();
            it.action = ACT_TICK;
            send_item(it, ROW_PRED, '0);
        end
        snd_sparse = 1'b0;
        // a timeout equal to the current age trips on the next tick
        cfg_write(REG_TIMEOUT_LIMIT, 16'(AGING_TICKS));
        cfg_write(REG_RESEND_TICKS, 16'd0);
        it.action = ACT_TICK;
        send_item(it, ROW_PRED, '0);

        // random phases, each with its own register settings and idle pattern
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            program_phase(ph);
            snd_quiet = (ph == 4) || ($urandom_range(0, 3) == 0);
            rcv_quiet = (ph == 4) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 39) == 0) drain_results();
                send_item(rand_item(), ROW_PRED, '0);
            end
        end

        drain_results();
        if (!failed)
            $display("** velocity_command_gate_watchdog: PASSED **");
        else
            $display("** velocity_command_gate_watchdog: FAILED **");
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached", $time);
        $display("** velocity_command_gate_watchdog: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/vcgw_pkg.sv
rtl/vcgw_in_if.sv
rtl/vcgw_out_if.sv
rtl/vcgw_cfg.sv
rtl/vcgw_shape.sv
rtl/vcgw_ctrl.sv
rtl/velocity_command_gate_watchdog.sv
test/tb.sv
